### rtl/rational_arithmetic_unit_macros.svh
// Assertion macros shared by the rational arithmetic unit RTL.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rau_pkg.sv
// Types and constants of the rational arithmetic unit.
`timescale 1ns / 1ps

package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int FIELD_W           = 16;
  localparam int NUM_W             = 33;
  localparam int DEN_W             = 31;
  localparam int CMD_W             = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_LESS = 3'd4,
    CMD_GT   = 3'd5,
    CMD_EQ   = 3'd6
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [FIELD_W-1:0] a_num;
    logic signed [FIELD_W-1:0] a_den;
    logic signed [FIELD_W-1:0] b_num;
    logic signed [FIELD_W-1:0] b_den;
  } item_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] res_num;
    logic [DEN_W-1:0]        res_den;
    logic                    compare_true;
  } result_t;

endpackage

### rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: one transfer in per cycle while item_stall is low, reduced
// fraction or compare flag out after the sign/magnitude, cross-product and combine stages,
// the gcd stages, the division stages and the result register. The gcd is a binary gcd with
// one step per stage, the reduction a restoring divider with one quotient bit per stage; the
// whole pipe advances only while the result register is free or taken, so res_stall holds
// every stage and item_stall follows it.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_macros.svh"

module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  rau_pkg::item_t  item,
  output logic            res_valid,
  input  logic            res_stall,
  output rau_pkg::result_t res
);
  import rau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int MW = 2 * W + 1;
  localparam int NG = 2 * MW + 2;
  localparam int KW = $clog2(MW + 1);
  localparam int NX = ((MW > NUM_W) ? MW : NUM_W) + 1;
  localparam int DX = (MW > DEN_W) ? MW : DEN_W;

  logic en;
  assign en         = !(res_valid && res_stall);
  assign item_stall = !en;

  // stage 1: sign and magnitude
  logic             s1_valid;
  logic [CMD_W-1:0] s1_cmd;
  logic             s1_an_s, s1_ad_s, s1_bn_s, s1_bd_s;
  logic [W-1:0]     s1_an_m, s1_ad_m, s1_bn_m, s1_bd_m;
  logic [W-1:0]     op_an, op_ad, op_bn, op_bd;

  assign op_an = W'($unsigned(item.a_num));
  assign op_ad = W'($unsigned(item.a_den));
  assign op_bn = W'($unsigned(item.b_num));
  assign op_bd = W'($unsigned(item.b_den));

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd  <= item.command;
      s1_an_s <= op_an[W-1];
      s1_ad_s <= op_ad[W-1];
      s1_bn_s <= op_bn[W-1];
      s1_bd_s <= op_bd[W-1];
      s1_an_m <= op_an[W-1] ? -op_an : op_an;
      s1_ad_m <= op_ad[W-1] ? -op_ad : op_ad;
      s1_bn_m <= op_bn[W-1] ? -op_bn : op_bn;
      s1_bd_m <= op_bd[W-1] ? -op_bd : op_bd;
    end
  end

  // stage 2: cross products
  logic             s2_valid;
  logic [CMD_W-1:0] s2_cmd;
  logic [PW-1:0]    s2_p1, s2_p2, s2_p3, s2_p4;
  logic             s2_s1, s2_s2, s2_s3, s2_s4, s2_cl, s2_cr;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cmd <= s1_cmd;
      s2_p1  <= s1_an_m * s1_bd_m;
      s2_p2  <= s1_bn_m * s1_ad_m;
      s2_p3  <= s1_an_m * s1_bn_m;
      s2_p4  <= s1_ad_m * s1_bd_m;
      s2_s1  <= s1_an_s ^ s1_bd_s;
      s2_s2  <= s1_bn_s ^ s1_ad_s;
      s2_s3  <= s1_an_s ^ s1_bn_s;
      s2_s4  <= s1_ad_s ^ s1_bd_s;
      s2_cl  <= s1_an_s ^ s1_ad_s;
      s2_cr  <= s1_bn_s ^ s1_bd_s;
    end
  end

  // stage 3: combine into numerator and denominator, or compare
  logic [MW-1:0] x_m, y_m, sum_m, c_num_m, c_den_m, den_fix_m;
  logic          x_s, y_s, sum_s, c_num_s, c_den_s, c_flag, c_neg;
  logic          l_s, r_s, c_eq, c_lt;

  always_comb begin
    x_m = MW'(s2_p1);
    y_m = MW'(s2_p2);
    x_s = s2_s1 && (s2_p1 != '0);
    y_s = (s2_p2 != '0) && ((cmd_t'(s2_cmd) == CMD_SUB) ? !s2_s2 : s2_s2);
    if (x_s == y_s) begin
      sum_m = x_m + y_m;
      sum_s = x_s;
    end else if (x_m >= y_m) begin
      sum_m = x_m - y_m;
      sum_s = x_s;
    end else begin
      sum_m = y_m - x_m;
      sum_s = y_s;
    end

    l_s  = s2_cl && (s2_p1 != '0);
    r_s  = s2_cr && (s2_p2 != '0);
    c_eq = (l_s == r_s) && (s2_p1 == s2_p2);
    if (l_s != r_s) begin
      c_lt = l_s;
    end else if (l_s) begin
      c_lt = s2_p1 > s2_p2;
    end else begin
      c_lt = s2_p1 < s2_p2;
    end

    c_num_m = '0;
    c_num_s = 1'b0;
    c_den_m = MW'(s2_p4);
    c_den_s = s2_s4;
    c_flag  = 1'b0;
    case (cmd_t'(s2_cmd))
      CMD_ADD, CMD_SUB: begin
        c_num_m = sum_m;
        c_num_s = sum_s;
      end
      CMD_MUL: begin
        c_num_m = MW'(s2_p3);
        c_num_s = s2_s3;
      end
      CMD_DIV: begin
        c_num_m = MW'(s2_p1);
        c_num_s = s2_s1;
        c_den_m = MW'(s2_p2);
        c_den_s = s2_s2;
      end
      CMD_LESS: begin
        c_den_m = MW'(1);
        c_den_s = 1'b0;
        c_flag  = c_lt;
      end
      CMD_GT: begin
        c_den_m = MW'(1);
        c_den_s = 1'b0;
        c_flag  = !c_lt && !c_eq;
      end
      CMD_EQ: begin
        c_den_m = MW'(1);
        c_den_s = 1'b0;
        c_flag  = c_eq;
      end
      default: begin
        c_den_m = MW'(1);
        c_den_s = 1'b0;
      end
    endcase
    den_fix_m = (c_den_m == '0) ? MW'(1) : c_den_m;
    c_neg     = (c_num_s ^ (c_den_s && (c_den_m != '0))) && (c_num_m != '0);
  end

  // binary gcd, one step per stage
  logic          g_valid [0:NG];
  logic [MW-1:0] g_u     [0:NG];
  logic [MW-1:0] g_v     [0:NG];
  logic [KW-1:0] g_k     [0:NG];
  logic [MW-1:0] g_nm    [0:NG];
  logic [MW-1:0] g_dm    [0:NG];
  logic          g_neg   [0:NG];
  logic          g_flag  [0:NG];

  always_ff @(posedge clk) begin
    logic [MW-1:0] nu, nv;
    logic [KW-1:0] nk;
    if (en) begin
      g_u[0]    <= c_num_m;
      g_v[0]    <= den_fix_m;
      g_k[0]    <= '0;
      g_nm[0]   <= c_num_m;
      g_dm[0]   <= den_fix_m;
      g_neg[0]  <= c_neg;
      g_flag[0] <= c_flag;
      for (int s = 0; s < NG; s++) begin
        nu = g_u[s];
        nv = g_v[s];
        nk = g_k[s];
        if (nu != '0 && nv != '0) begin
          if (!nu[0] && !nv[0]) begin
            nu = nu >> 1;
            nv = nv >> 1;
            nk = nk + KW'(1);
          end else if (!nu[0]) begin
            nu = nu >> 1;
          end else if (!nv[0]) begin
            nv = nv >> 1;
          end else if (nu >= nv) begin
            nu = (nu - nv) >> 1;
          end else begin
            nv = (nv - nu) >> 1;
          end
        end
        g_nm[s+1]   <= g_nm[s];
        g_dm[s+1]   <= g_dm[s];
        g_neg[s+1]  <= g_neg[s];
        g_flag[s+1] <= g_flag[s];
        g_u[s+1]    <= nu;
        g_v[s+1]    <= nv;
        g_k[s+1]    <= nk;
      end
    end
  end

  // restoring division of both parts by the gcd, one quotient bit per stage
  logic          d_valid [0:MW];
  logic [MW-1:0] d_g     [0:MW];
  logic [MW-1:0] d_rn    [0:MW];
  logic [MW-1:0] d_qn    [0:MW];
  logic [MW-1:0] d_rd    [0:MW];
  logic [MW-1:0] d_qd    [0:MW];
  logic          d_neg   [0:MW];
  logic          d_flag  [0:MW];

  always_ff @(posedge clk) begin
    logic [MW:0] tn, td;
    if (en) begin
      d_g[0]    <= (g_u[NG] | g_v[NG]) << g_k[NG];
      d_rn[0]   <= '0;
      d_qn[0]   <= g_nm[NG];
      d_rd[0]   <= '0;
      d_qd[0]   <= g_dm[NG];
      d_neg[0]  <= g_neg[NG];
      d_flag[0] <= g_flag[NG];
      for (int s = 0; s < MW; s++) begin
        tn = {d_rn[s], d_qn[s][MW-1]};
        td = {d_rd[s], d_qd[s][MW-1]};
        d_g[s+1]    <= d_g[s];
        d_neg[s+1]  <= d_neg[s];
        d_flag[s+1] <= d_flag[s];
        if (tn >= {1'b0, d_g[s]}) begin
          d_rn[s+1] <= MW'(tn - {1'b0, d_g[s]});
          d_qn[s+1] <= {d_qn[s][MW-2:0], 1'b1};
        end else begin
          d_rn[s+1] <= MW'(tn);
          d_qn[s+1] <= {d_qn[s][MW-2:0], 1'b0};
        end
        if (td >= {1'b0, d_g[s]}) begin
          d_rd[s+1] <= MW'(td - {1'b0, d_g[s]});
          d_qd[s+1] <= {d_qd[s][MW-2:0], 1'b1};
        end else begin
          d_rd[s+1] <= MW'(td);
          d_qd[s+1] <= {d_qd[s][MW-2:0], 1'b0};
        end
      end
    end
  end

  // result register
  logic [NX-1:0] n_ext;
  logic [DX-1:0] d_ext;
  assign n_ext = NX'(d_qn[MW]);
  assign d_ext = DX'(d_qd[MW]);

  always_ff @(posedge clk) begin
    if (en) begin
      res.res_num      <= NUM_W'(d_neg[MW] ? -n_ext : n_ext);
      res.res_den      <= DEN_W'(d_ext);
      res.compare_true <= d_flag[MW];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
      for (int s = 0; s <= NG; s++) begin
        g_valid[s] <= 1'b0;
      end
      for (int s = 0; s <= MW; s++) begin
        d_valid[s] <= 1'b0;
      end
    end else if (en) begin
      s1_valid   <= item_valid;
      s2_valid   <= s1_valid;
      g_valid[0] <= s2_valid;
      for (int s = 0; s < NG; s++) begin
        g_valid[s+1] <= g_valid[s];
      end
      d_valid[0] <= g_valid[NG];
      for (int s = 0; s < MW; s++) begin
        d_valid[s+1] <= d_valid[s];
      end
      res_valid <= d_valid[MW];
    end
  end

  `RAU_ASSERT_NOW(a_gcd_nonzero, d_valid[0], d_g[0] != '0, "gcd of zero reached divider")
  `RAU_ASSERT_NOW(a_div_exact, d_valid[MW], d_rn[MW] == '0 && d_rd[MW] == '0, "inexact reduction")
  `RAU_ASSERT_NOW(a_den_nonzero, res_valid, res.res_den != '0 || MW > DEN_W, "zero denominator")
  `RAU_ASSERT_NOW(a_cmp_form, res_valid && res.compare_true,
                  res.res_num == '0 && res.res_den == DEN_W'(1), "compare result not 0/1")

endmodule

### tb/rau_checker.sv
// Checker for the rational arithmetic unit: predicts each result and compares transfers.
`timescale 1ns / 1ps

module rau_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  rau_pkg::item_t   item,
  input  logic             res_valid,
  input  logic             res_stall,
  input  rau_pkg::result_t res,
  output int               fail_count,
  output int               pending
);
  import rau_pkg::*;

  result_t expected_q[$];

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic result_t reduce_fraction(item_t it);
    result_t r;
    longint an, ad, bn, bd, num, den, lhs, rhs;
    longint unsigned nm, dm, g;
    an = longint'(it.a_num);
    ad = longint'(it.a_den);
    bn = longint'(it.b_num);
    bd = longint'(it.b_den);
    r.res_num = '0;
    r.res_den = DEN_W'(1);
    r.compare_true = 1'b0;
    if (it.command >= CMD_LESS) begin
      if (ad < 0) begin an = -an; ad = -ad; end
      if (bd < 0) begin bn = -bn; bd = -bd; end
      lhs = an * bd;
      rhs = bn * ad;
      case (it.command)
        CMD_LESS: r.compare_true = lhs < rhs;
        CMD_GT:   r.compare_true = lhs > rhs;
        CMD_EQ:   r.compare_true = lhs == rhs;
        default:  r.compare_true = 1'b0;
      endcase
      return r;
    end
    case (it.command)
      CMD_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
      CMD_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
      CMD_MUL: begin num = an * bn; den = ad * bd; end
      default: begin num = an * bd; den = ad * bn; end
    endcase
    if (den == 0) den = 1;
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    g = gcd_of(nm, dm);
    nm = nm / g;
    dm = dm / g;
    num = ((num < 0) != (den < 0)) ? -longint'(nm) : longint'(nm);
    r.res_num = num[NUM_W-1:0];
    r.res_den = dm[DEN_W-1:0];
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (item_valid && !item_stall) expected_q.push_back(reduce_fraction(item));
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer %p", res);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.res_num !== res.res_num || e.res_den !== res.res_den ||
              e.compare_true !== res.compare_true) begin
            if (fail_count < 10)
              $display("mismatch: exp %0d/%0d cmp %0b, got %0d/%0d cmp %0b",
                       e.res_num, e.res_den, e.compare_true,
                       res.res_num, res.res_den, res.compare_true);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### tb/tb.sv
// Testbench top for the rational arithmetic unit: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;
  import rau_pkg::*;

  localparam int WATCHDOG = 5000;
  localparam int DRAIN    = 300;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    res_valid;
  logic    res_stall = 1'b0;
  result_t res;
  int      fail_count, pending;
  int      idle_cycles = 0;
  bit      stim_done = 1'b0;

  always #2 clk = ~clk;

  rational_arithmetic_unit uut (
    .clk, .rst, .item_valid, .item_stall, .item, .res_valid, .res_stall, .res
  );

  rau_checker chk (
    .clk, .rst, .item_valid, .item_stall, .item, .res_valid, .res_stall, .res,
    .fail_count, .pending
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 40)) - 20);
      3: return 16'($urandom_range(0, 255));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send(item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      item_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic send_fields(logic [2:0] c, int an, int ad, int bn, int bd);
    item_t it;
    it.command = c;
    it.a_num = 16'(an);
    it.a_den = 16'(ad);
    it.b_num = 16'(bn);
    it.b_den = 16'(bd);
    send(it);
  endtask

  // receiver stalls: random bursts, with long clear stretches
  always @(posedge clk) begin
    if (rst) res_stall <= 1'b0;
    else if (($urandom_range(0, 999) < 5)) res_stall <= 1'b0;
    else if (($urandom_range(0, 99) < 8)) res_stall <= ~res_stall;
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    item_t it;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_fields(CMD_ADD, 1, 2, 1, 3);
    send_fields(CMD_SUB, 1, 2, 1, 2);
    send_fields(CMD_MUL, -32768, -32768, -32768, -32768);
    send_fields(CMD_MUL, 32767, 1, 32767, 1);
    send_fields(CMD_DIV, 3, 4, 0, 5);
    send_fields(CMD_DIV, -32768, 32767, 32767, -32768);
    send_fields(CMD_ADD, 5, 0, 7, 0);
    send_fields(CMD_ADD, 0, 9, 0, -4);
    send_fields(CMD_SUB, -32768, 1, 32767, 1);
    send_fields(CMD_ADD, 6, -4, 3, 8);
    send_fields(CMD_LESS, 1, -2, 1, 3);
    send_fields(CMD_LESS, 1, 3, 1, -2);
    send_fields(CMD_GT, -1, -2, 1, 3);
    send_fields(CMD_EQ, 2, 4, -1, -2);
    send_fields(CMD_EQ, 5, 0, 3, 7);
    send_fields(CMD_GT, -32768, -32768, 32767, 32767);
    send_fields(3'd7, 1, 2, 3, 4);
    send_fields(CMD_EQ, 0, 0, 0, 0);
    for (int n = 0; n < 1350; n++) begin
      it.command = 3'($urandom_range(0, 7));
      it.a_num = rand_field();
      it.a_den = rand_field();
      it.b_num = rand_field();
      it.b_den = rand_field();
      send(it);
    end
    item_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int waited;
    wait (stim_done);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    waited = 0;
    while (waited < DRAIN) begin
      @(posedge clk);
      waited++;
    end
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/rau_pkg.sv
rtl/rational_arithmetic_unit.sv
tb/rau_checker.sv
tb/tb.sv
